FILE: src/tea_block_encrypt_unit_assert.svh
// Assertion macros for the TEA block encrypt unit.
`ifndef TEA_BLOCK_ENCRYPT_UNIT_ASSERT_SVH
`define TEA_BLOCK_ENCRYPT_UNIT_ASSERT_SVH

`ifndef SYNTH

// Antecedent holds -> consequent holds in the same cycle.
`define TEA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tea assertion failed");

// Antecedent holds -> consequent holds in the next cycle.
`define TEA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tea assertion failed");

`else

`define TEA_ASSERT_NOW(lbl, ante, cons)
`define TEA_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

FILE: src/tea_pkg.sv
// Shared types, constants and round functions for the TEA block encrypt unit.
package tea_pkg;

    localparam int unsigned ROUND_COUNT = 16;
    localparam int unsigned STAGE_COUNT = 2 * ROUND_COUNT;
    localparam int unsigned WORD_W      = 32;
    localparam int unsigned KEY_WORDS   = 4;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam logic [WORD_W-1:0] TEA_DELTA = 32'h9e37_79b9;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD0 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD1 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD3 = 2'd3;

    typedef logic [WORD_W-1:0] t_word;

    typedef struct packed {
        t_word z;   // second word (upper half of tdata)
        t_word y;   // first word (lower half of tdata)
    } t_blk;

    typedef t_word [KEY_WORDS-1:0] t_key;

    // Running sum after round r (0-based): delta * (r + 1), wraps mod 2^32.
    function automatic t_word tea_sum(input int unsigned r);
        logic [63:0] prod;
        begin
            prod = 64'(TEA_DELTA) * 64'(r + 1);
            return prod[WORD_W-1:0];
        end
    endfunction

    function automatic t_word tea_mix(input t_word x, input t_word sum,
                                      input t_word ka, input t_word kb);
        begin
            return ((x << 4) + ka) ^ (x + sum) ^ ((x >> 5) + kb);
        end
    endfunction

endpackage

FILE: src/tea_key_regs.sv
// Key word registers written through the configuration port.
module tea_key_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [tea_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [tea_pkg::WORD_W-1:0] i_cfg_data,
    output tea_pkg::t_key              o_key
);
    import tea_pkg::*;

    t_key r_key;
    t_key n_key;

    always_comb begin
        n_key = r_key;
        if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_KEY_WORD0: n_key[0] = i_cfg_data;
                REG_KEY_WORD1: n_key[1] = i_cfg_data;
                REG_KEY_WORD2: n_key[2] = i_cfg_data;
                REG_KEY_WORD3: n_key[3] = i_cfg_data;
                default:       n_key = r_key;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
        end else begin
            r_key <= n_key;
        end
    end

    assign o_key = r_key;

endmodule

FILE: src/tea_half_round.sv
// One pipeline stage: half a TEA round (update of the first or the second word).
module tea_half_round (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_upd_second,
    input  tea_pkg::t_word i_sum,
    input  tea_pkg::t_word i_ka,
    input  tea_pkg::t_word i_kb,
    input  logic          i_valid,
    input  tea_pkg::t_blk i_blk,
    output logic          o_valid,
    output tea_pkg::t_blk o_blk
);
    import tea_pkg::*;

    logic  r_valid;
    t_blk  r_blk;
    t_blk  n_blk;
    t_word src;
    t_word dst;
    t_word upd;

    // first half: y += mix(z); second half: z += mix(y)
    assign src = i_upd_second ? i_blk.y : i_blk.z;
    assign dst = i_upd_second ? i_blk.z : i_blk.y;
    assign upd = dst + tea_mix(src, i_sum, i_ka, i_kb);

    always_comb begin
        n_blk = i_blk;
        if (i_upd_second) begin
            n_blk.z = upd;
        end else begin
            n_blk.y = upd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_blk <= n_blk;
        end
    end

    assign o_valid = r_valid;
    assign o_blk   = r_blk;

endmodule

FILE: src/tea_block_encrypt_unit.sv
// Top level: pipelined TEA block encryption, one half round per stage.
//
//  channel   direction  ports                          payload
//  -------   ---------  -----------------------------  ------------------------------------
//  in        slave      i_s_tvalid/o_s_tready          i_s_tdata: plain_first, plain_second
//  out       master     o_m_tvalid/i_m_tready          o_m_tdata: cipher_first, cipher_second
//  cfg       write      i_cfg_wr_en                    i_cfg_index, i_cfg_data (key words)
//
//  Each round is split into a first-word stage and a second-word stage, and the last
//  stage is the output register.
//  Throughput is one block per cycle while the output side takes requests.
//  The whole pipeline advances on one enable: it moves when the output register
//  is empty or being taken; a stall freezes every stage, bubbles included.
//  Reset (synchronous, active low) clears stage valids and key words to zero.
`include "tea_block_encrypt_unit_assert.svh"

module tea_block_encrypt_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // in request
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [63:0]                   i_s_tdata,   // [31:0] plain_first, [63:32] plain_second
    // out request
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [63:0]                   o_m_tdata,   // [31:0] cipher_first, [63:32] cipher_second
    // configuration
    input  logic                          i_cfg_wr_en,
    input  logic [tea_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [tea_pkg::WORD_W-1:0]    i_cfg_data
);
    import tea_pkg::*;

    t_key                 key;
    logic                 pipe_en;
    logic [STAGE_COUNT:0] valid;
    t_blk                 blk [STAGE_COUNT+1];

    tea_key_regs u_key_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_key       (key)
    );

    // global advance: last stage empty or its request being taken
    assign pipe_en    = !valid[STAGE_COUNT] || i_m_tready;
    assign o_s_tready = pipe_en;

    assign valid[0] = i_s_tvalid;
    assign blk[0]   = i_s_tdata;

    for (genvar s = 0; s < STAGE_COUNT; s++) begin : g_stage
        localparam bit SECOND = (s % 2) == 1;
        tea_half_round u_half (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_en         (pipe_en),
            .i_upd_second (SECOND),
            .i_sum        (tea_sum(s / 2)),
            .i_ka         (SECOND ? key[2] : key[0]),
            .i_kb         (SECOND ? key[3] : key[1]),
            .i_valid      (valid[s]),
            .i_blk        (blk[s]),
            .o_valid      (valid[s+1]),
            .o_blk        (blk[s+1])
        );
    end

    assign o_m_tvalid = valid[STAGE_COUNT];
    assign o_m_tdata  = blk[STAGE_COUNT];

    // stall freezes every stage valid
    `TEA_ASSERT_NEXT(a_stall_freeze, !pipe_en, valid[STAGE_COUNT:1] == $past(valid[STAGE_COUNT:1]))
    // on advance each valid moves down exactly one stage
    `TEA_ASSERT_NEXT(a_valid_shift, pipe_en, valid[STAGE_COUNT:1] == $past(valid[STAGE_COUNT-1:0]))
    // accepted request lands in the first stage
    `TEA_ASSERT_NEXT(a_accept_lands, i_s_tvalid && o_s_tready, valid[1])

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for the TEA block encrypt unit: stream driver, monitor, predictor.
module tb_top;
    import tea_pkg::*;

    localparam int unsigned CLK_HALF      = 5;
    localparam int unsigned RESET_CYCLES  = 8;
    localparam int unsigned PIPE_LATENCY  = 2 * ROUND_COUNT;
    localparam int unsigned STALL_LIMIT   = 4000;
    localparam int unsigned ITEMS_PER_SET = 205;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_s_tvalid  = 1'b0;
    logic                 o_s_tready;
    logic [63:0]          i_s_tdata   = '0;
    logic                 o_m_tvalid;
    logic                 i_m_tready  = 1'b0;
    logic [63:0]          o_m_tdata;
    logic                 i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [WORD_W-1:0]    i_cfg_data  = '0;

    // Predictor state: key copy, blocks waiting to go in, ciphertext waiting to come out
    t_word       cipher_key [KEY_WORDS];
    t_blk        plain_q [$];
    t_blk        cipher_q [$];
    int unsigned send_idle_pct = 6;
    int unsigned recv_idle_pct = 49;
    int unsigned err_count     = 0;
    int unsigned stall_cycles  = 0;
    logic        drv_busy;

    tea_block_encrypt_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // TEA encryption of one block under the current key, all sums mod 2^32
    function automatic t_blk tea_encrypt(input t_blk plain);
        t_word y;
        t_word z;
        t_word sum;
        t_blk  res;
        y   = plain.y;
        z   = plain.z;
        sum = '0;
        for (int unsigned r = 0; r < ROUND_COUNT; r++) begin
            sum = sum + TEA_DELTA;
            y   = y + (((z << 4) + cipher_key[0]) ^ (z + sum) ^ ((z >> 5) + cipher_key[1]));
            z   = z + (((y << 4) + cipher_key[2]) ^ (y + sum) ^ ((y >> 5) + cipher_key[3]));
        end
        res.y = y;
        res.z = z;
        return res;
    endfunction

    // Words biased toward the extremes, the rest fully random
    function automatic t_word rand_word();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    // Input side: present queued blocks, record the expected cipher on each accepted request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            drv_busy = i_s_tvalid;
            if (i_s_tvalid && o_s_tready) begin
                cipher_q.push_back(tea_encrypt(t_blk'(i_s_tdata)));
                drv_busy = 1'b0;
            end
            if (!drv_busy) begin
                if (plain_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_s_tdata  <= plain_q.pop_front();
                    i_s_tvalid <= 1'b1;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Output side: random backpressure, compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        t_blk got;
        t_blk want;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                got = t_blk'(o_m_tdata);
                if (cipher_q.size() == 0) begin
                    $display("%0t: unexpected result, actual %h", $time, o_m_tdata);
                    err_count++;
                end else begin
                    want = cipher_q.pop_front();
                    if (got.y !== want.y) begin
                        $display("%0t: cipher_first expected %h actual %h",
                                 $time, want.y, got.y);
                        err_count++;
                    end
                    if (got.z !== want.z) begin
                        $display("%0t: cipher_second expected %h actual %h",
                                 $time, want.z, got.z);
                        err_count++;
                    end
                end
            end
            i_m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: cycles without any accepted request on either side
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("FAIL tea_block_encrypt_unit");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input t_word value);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        cipher_key[idx] = value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic load_key(input t_word k0, input t_word k1, input t_word k2, input t_word k3);
        write_reg(REG_KEY_WORD0, k0);
        write_reg(REG_KEY_WORD1, k1);
        write_reg(REG_KEY_WORD2, k2);
        write_reg(REG_KEY_WORD3, k3);
    endtask

    // Block is idle once nothing is queued, presented or in flight
    task automatic wait_drained();
        @(negedge i_clk);
        while (plain_q.size() != 0 || i_s_tvalid || cipher_q.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic queue_directed();
        t_word pat [10][2];
        t_blk  blk;
        pat = '{'{32'h0000_0000, 32'h0000_0000}, '{32'hffff_ffff, 32'hffff_ffff},
                '{32'h0000_0000, 32'hffff_ffff}, '{32'hffff_ffff, 32'h0000_0000},
                '{32'h0000_0001, 32'h0000_0000}, '{32'h0000_0000, 32'h0000_0001},
                '{32'h8000_0000, 32'h0000_0000}, '{32'h0000_0000, 32'h8000_0000},
                '{32'haaaa_aaaa, 32'h5555_5555}, '{32'h5555_5555, 32'haaaa_aaaa}};
        for (int i = 0; i < 10; i++) begin
            blk.y = pat[i][0];
            blk.z = pat[i][1];
            plain_q.push_back(blk);
        end
    endtask

    initial begin
        t_blk blk;
        for (int j = 0; j < KEY_WORDS; j++)
            cipher_key[j] = '0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: key never written (all zero), then the all-ones key
        queue_directed();
        wait_drained();
        load_key('1, '1, '1, '1);
        queue_directed();
        wait_drained();

        // Random: three idling modes, three key settings each
        for (int mode = 0; mode < 3; mode++) begin
            case (mode)
                0: begin send_idle_pct = 6;  recv_idle_pct = 49; end
                1: begin send_idle_pct = 49; recv_idle_pct = 6;  end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            for (int set = 0; set < 3; set++) begin
                if (set == 1) begin
                    case (mode)
                        0: load_key('1, '1, '1, '1);
                        1: load_key('0, '0, '0, '0);
                        default: load_key('0, '1, '0, '1);
                    endcase
                end else begin
                    load_key($urandom, $urandom, $urandom, $urandom);
                end
                for (int n = 0; n < ITEMS_PER_SET; n++) begin
                    blk.y = rand_word();
                    blk.z = rand_word();
                    plain_q.push_back(blk);
                end
                wait_drained();
            end
        end

        // Let the pipeline run empty to catch any stray result
        repeat (PIPE_LATENCY + 8) @(posedge i_clk);
        @(negedge i_clk);
        if (err_count == 0)
            $display("PASS tea_block_encrypt_unit");
        else
            $display("FAIL tea_block_encrypt_unit");
        $finish;
    end
endmodule
